// ===== rtl/core/lfpd_pkg.sv =====
// lfpd_pkg: shared types, widths and register codes for the line follower PID drive.
// No dependencies; imported by every other file of the block.
`default_nettype none

package lfpd_pkg;

  localparam int SAMPLE_W     = 12;
  localparam int GAIN_W       = 24;
  localparam int SPEED_CAP_W  = 23;
  localparam int SPEED_W      = 24;
  localparam int SUM_W        = 32;
  localparam int ERR_W        = 2;
  localparam int DERR_W       = 3;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 24;
  localparam int PROD_W       = GAIN_W + 1 + SUM_W;  // signed gain_i_step * error sum
  localparam int PD_W         = GAIN_W + 3;          // p and d terms together
  localparam int TERM_W       = PROD_W + 1;

  localparam int LFPD_QUEUE_DEPTH = 4;

  localparam logic [SAMPLE_W-1:0]    RST_LINE_THRESHOLD = 12'd300;
  localparam logic [GAIN_W-1:0]      RST_GAIN_P         = 24'd52429;
  localparam logic [GAIN_W-1:0]      RST_GAIN_I_STEP    = 24'd0;
  localparam logic [GAIN_W-1:0]      RST_GAIN_D_STEP    = 24'd102;
  localparam logic [SPEED_CAP_W-1:0] RST_SPEED_CAP      = 23'd411566;

  localparam logic signed [SUM_W-1:0] SUM_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [SUM_W-1:0] SUM_MIN = 32'sh8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_THRESHOLD = 3'd0,
    CFG_GAIN_P         = 3'd1,
    CFG_GAIN_I_STEP    = 3'd2,
    CFG_GAIN_D_STEP    = 3'd3,
    CFG_SPEED_CAP      = 3'd4
  } lfpd_cfg_idx_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] left_sample;
    logic [SAMPLE_W-1:0] center_sample;
    logic [SAMPLE_W-1:0] right_sample;
  } lfpd_in_t;

  typedef struct packed {
    logic signed [ERR_W-1:0]   line_error;
    logic                      line_lost;
    logic signed [SPEED_W-1:0] left_spd;
    logic signed [SPEED_W-1:0] right_spd;
  } lfpd_out_t;

  // classified item handed from front to back
  typedef struct packed {
    logic signed [ERR_W-1:0]  err;
    logic                     lost;
    logic signed [SUM_W-1:0]  sum;
    logic signed [DERR_W-1:0] derr;
  } lfpd_cmd_t;

  typedef struct packed {
    logic [GAIN_W-1:0]      gain_p;
    logic [GAIN_W-1:0]      gain_i_step;
    logic [GAIN_W-1:0]      gain_d_step;
    logic [SPEED_CAP_W-1:0] speed_cap;
  } lfpd_gains_t;

endpackage

`default_nettype wire

// ===== rtl/core/lfpd_if.sv =====
// lfpd_if: valid/ready channel interfaces for sensor items and drive items.
// Depends on lfpd_pkg for the payload types.
`default_nettype none

interface lfpd_in_if;
  import lfpd_pkg::*;
  logic     valid;
  logic     ready;
  lfpd_in_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface lfpd_out_if;
  import lfpd_pkg::*;
  logic      valid;
  logic      ready;
  lfpd_out_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lfpd_front.sv =====
// lfpd_front: accepts sensor items, classifies the line error, keeps the error
// sum and last error. Depends on lfpd_pkg and lfpd_if.
`default_nettype none

module lfpd_front (
  input  logic                          clk,
  input  logic                          rst_n,
  lfpd_in_if.sink                       in_ch,
  input  logic [lfpd_pkg::SAMPLE_W-1:0] threshold,
  input  logic                          q_full,
  output logic                          q_push,
  output lfpd_pkg::lfpd_cmd_t           q_data
);
  import lfpd_pkg::*;

  logic signed [ERR_W-1:0] last_err_r, last_err_nxt;
  logic signed [SUM_W-1:0] err_sum_r, err_sum_nxt;
  logic signed [SUM_W:0]   sum_wide;
  logic                    l_hit, c_hit, r_hit, lost;
  logic signed [ERR_W-1:0] err;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    c_hit = in_ch.data.center_sample < threshold;
    l_hit = in_ch.data.left_sample < threshold;
    r_hit = in_ch.data.right_sample < threshold;
    lost  = 1'b0;
    if (c_hit) begin
      err = 2'sd0;
    end else if (l_hit) begin
      err = -2'sd1;
    end else if (r_hit) begin
      err = 2'sd1;
    end else begin
      err  = last_err_r;
      lost = 1'b1;
    end
    sum_wide = (SUM_W+1)'(err_sum_r) + (SUM_W+1)'(err);
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      err_sum_nxt = sum_wide[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      err_sum_nxt = sum_wide[SUM_W-1:0];
    end
    last_err_nxt = err;
  end

  assign q_data.err  = err;
  assign q_data.lost = lost;
  assign q_data.sum  = err_sum_nxt;
  assign q_data.derr = DERR_W'(err) - DERR_W'(last_err_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_err_r <= '0;
      err_sum_r  <= '0;
    end else if (q_push) begin
      last_err_r <= last_err_nxt;
      err_sum_r  <= err_sum_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lfpd_queue.sv =====
// lfpd_queue: short FIFO of classified items between front and back.
// Depends on lfpd_pkg for the entry type.
`default_nettype none

module lfpd_queue #(
  parameter int DEPTH = lfpd_pkg::LFPD_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lfpd_pkg::lfpd_cmd_t push_data,
  output logic                full,
  input  logic                pop,
  output lfpd_pkg::lfpd_cmd_t pop_data,
  output logic                empty
);
  import lfpd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  lfpd_cmd_t        mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push, do_pop;

  assign full     = cnt_r == FULL_CNT;
  assign empty    = cnt_r == '0;
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/lfpd_back.sv =====
// lfpd_back: PID term and wheel speed pipeline: products, term, clamped output register.
// Depends on lfpd_pkg and lfpd_if.
`default_nettype none

module lfpd_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  lfpd_pkg::lfpd_gains_t gains,
  input  logic                  q_empty,
  input  lfpd_pkg::lfpd_cmd_t   q_data,
  output logic                  q_pop,
  lfpd_out_if.source            out_ch
);
  import lfpd_pkg::*;

  logic                      advance;
  // stage 1: products
  logic                      s1_v_r;
  logic signed [ERR_W-1:0]   s1_err_r;
  logic                      s1_lost_r;
  logic signed [PROD_W-1:0]  s1_prod_r, s1_prod_nxt;
  logic signed [PD_W-1:0]    s1_pd_r, s1_pd_nxt;
  logic signed [PD_W-1:0]    p_term, d_term, gd_s;
  // stage 2: term
  logic                      s2_v_r;
  logic signed [ERR_W-1:0]   s2_err_r;
  logic                      s2_lost_r;
  logic signed [TERM_W-1:0]  s2_term_r, s2_term_nxt;
  // stage 3: output
  logic                      out_v_r;
  lfpd_out_t                 out_r, out_nxt;
  logic signed [TERM_W-1:0]  lim, ls_raw, rs_raw, ls_c, rs_c;

  assign advance = !out_v_r || out_ch.ready;
  assign q_pop   = advance && !q_empty;

  always_comb begin
    gd_s = PD_W'(gains.gain_d_step);
    case (q_data.err)
      2'sd1:   p_term = PD_W'(gains.gain_p);
      -2'sd1:  p_term = -PD_W'(gains.gain_p);
      default: p_term = '0;
    endcase
    case (q_data.derr)
      3'sd1:   d_term = gd_s;
      3'sd2:   d_term = gd_s <<< 1;
      -3'sd1:  d_term = -gd_s;
      -3'sd2:  d_term = -(gd_s <<< 1);
      default: d_term = '0;
    endcase
    s1_pd_nxt   = p_term + d_term;
    s1_prod_nxt = $signed({1'b0, gains.gain_i_step}) * q_data.sum;
  end

  assign s2_term_nxt = TERM_W'(s1_prod_r) + TERM_W'(s1_pd_r);

  always_comb begin
    lim    = TERM_W'($signed({1'b0, gains.speed_cap}));
    ls_raw = lim - s2_term_r;
    rs_raw = lim + s2_term_r;
    if (ls_raw > lim) begin
      ls_c = lim;
    end else if (ls_raw < -lim) begin
      ls_c = -lim;
    end else begin
      ls_c = ls_raw;
    end
    if (rs_raw > lim) begin
      rs_c = lim;
    end else if (rs_raw < -lim) begin
      rs_c = -lim;
    end else begin
      rs_c = rs_raw;
    end
    out_nxt.line_error = s2_err_r;
    out_nxt.line_lost  = s2_lost_r;
    out_nxt.left_spd   = ls_c[SPEED_W-1:0];
    out_nxt.right_spd  = rs_c[SPEED_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else if (advance) begin
      s1_v_r  <= !q_empty;
      s2_v_r  <= s1_v_r;
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_err_r  <= q_data.err;
      s1_lost_r <= q_data.lost;
      s1_prod_r <= s1_prod_nxt;
      s1_pd_r   <= s1_pd_nxt;
      s2_err_r  <= s1_err_r;
      s2_lost_r <= s1_lost_r;
      s2_term_r <= s2_term_nxt;
      out_r     <= out_nxt;
    end
  end

  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_r;

endmodule

`default_nettype wire

// ===== rtl/core/line_follow_pid_drive_top.sv =====
// line_follow_pid_drive_top: three-sensor line follower with PID wheel drive.
// Depends on lfpd_pkg, lfpd_if, lfpd_front, lfpd_queue and lfpd_back.
//
// in_ch carries one item of left, center and right reflectance samples;
// out_ch returns one item per input: line error, line-lost flag and the
// signed Q16 left and right wheel speeds. Both use valid/ready.
// cfg_we/cfg_index/cfg_wdata write the threshold, the three gains and
// the speed cap; the user must write only while no item is in flight, the block itself does not enforce it.
// An accepted item passes the queue, then the product, term and output
// registers to out_ch. Throughput: one item per cycle while out_ch is ready;
// the front computes the error and sum combinationally, the back is a three-stage
// pipeline (multiply, term add, speed clamp into the output register).
// Reset clears the error state, the queue and all valid bits and loads the
// register defaults. When out_ch stalls the back pipeline holds, and the
// front keeps accepting until the QUEUE_DEPTH-entry queue fills.
`default_nettype none

module line_follow_pid_drive_top #(
  parameter int QUEUE_DEPTH = lfpd_pkg::LFPD_QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  lfpd_in_if.sink                         in_ch,
  lfpd_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [lfpd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lfpd_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import lfpd_pkg::*;

  logic [SAMPLE_W-1:0] threshold_r;
  lfpd_gains_t         gains_r;
  logic                q_push, q_pop, q_full, q_empty;
  lfpd_cmd_t           q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r         <= RST_LINE_THRESHOLD;
      gains_r.gain_p      <= RST_GAIN_P;
      gains_r.gain_i_step <= RST_GAIN_I_STEP;
      gains_r.gain_d_step <= RST_GAIN_D_STEP;
      gains_r.speed_cap   <= RST_SPEED_CAP;
    end else if (cfg_we) begin
      case (lfpd_cfg_idx_t'(cfg_index))
        CFG_LINE_THRESHOLD: threshold_r         <= cfg_wdata[SAMPLE_W-1:0];
        CFG_GAIN_P:         gains_r.gain_p      <= cfg_wdata[GAIN_W-1:0];
        CFG_GAIN_I_STEP:    gains_r.gain_i_step <= cfg_wdata[GAIN_W-1:0];
        CFG_GAIN_D_STEP:    gains_r.gain_d_step <= cfg_wdata[GAIN_W-1:0];
        CFG_SPEED_CAP:      gains_r.speed_cap   <= cfg_wdata[SPEED_CAP_W-1:0];
        default: ;
      endcase
    end
  end

  lfpd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .threshold (threshold_r),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_data    (q_wdata)
  );

  lfpd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  lfpd_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .gains   (gains_r),
    .q_empty (q_empty),
    .q_data  (q_rdata),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire

// ===== rtl/core/lfpd_checker.sv =====
// lfpd_checker: port-level assertions for line_follow_pid_drive_top, with bind.
// Depends on lfpd_pkg and the top level.
`default_nettype none

module lfpd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input lfpd_pkg::lfpd_out_t out_data
);
  import lfpd_pkg::*;

  logic signed [SPEED_W:0] speed_sum;

  assign speed_sum = (SPEED_W+1)'(out_data.left_spd) + (SPEED_W+1)'(out_data.right_spd);

  // stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("out item changed while stalled");

  // offered input item stays offered until taken
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid)
    else $error("in item withdrawn while waiting");

  // clamping to +/- speed cap never lets the speeds sum below zero
  a_speed_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> speed_sum >= 0)
    else $error("wheel speeds sum negative");

  a_ranges: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.line_error != -2'sd2 &&
                  out_data.left_spd != {1'b1, {(SPEED_W-1){1'b0}}} &&
                  out_data.right_spd != {1'b1, {(SPEED_W-1){1'b0}}})
    else $error("result field out of range");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid && (in_ready || !rst_n))
    else $error("block not empty after reset");

endmodule

bind line_follow_pid_drive_top lfpd_checker u_lfpd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data)
);

`default_nettype wire
